// ----- rtl/core/rgb_to_hsv_defines.svh -----
// Assertion macros shared by the RGB to HSV converter RTL.
`ifndef RGB_TO_HSV_DEFINES_SVH
`define RGB_TO_HSV_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define RTH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/rth_pkg.sv -----
// Types, constants and the divider step shared by the RGB to HSV converter.
`timescale 1ns / 1ps
`default_nettype none

package rth_pkg;

    localparam int unsigned CH_W  = 8;
    localparam int unsigned HUE_W = 15;
    localparam int unsigned SUM_W = 9;
    localparam int unsigned DEN_W = 9;
    localparam int unsigned DIV_W = 22;
    localparam int unsigned QUO_W = 13;

    // Hue is in degrees times 64: 360 degrees is 23040.
    localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;
    // Sector base minus 60 degrees, since the divider sees n + d instead of n.
    localparam logic [HUE_W-1:0] OFS_RED   = 15'd19200;
    localparam logic [HUE_W-1:0] OFS_GREEN = 15'd3840;
    localparam logic [HUE_W-1:0] OFS_BLUE  = 15'd11520;

    // Twice the 60 degree scale, and twice 255, for round-to-nearest numerators.
    localparam logic [12:0] HUE_SCALE2 = 13'd7680;
    localparam logic [8:0]  SAT_SCALE2 = 9'd510;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb_pix;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_hsv_pix;

    // One restoring-division lane: partial remainder and quotient so far.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    // Work item that travels down the divider pipeline.
    typedef struct packed {
        t_div_lane        hue;
        t_div_lane        sat;
        logic [DEN_W-1:0] hue_den;
        logic [DEN_W-1:0] sat_den;
        t_sector          sector;
        logic             grey;
        logic [CH_W-1:0]  brightness;
    } t_div_work;

    // Produce one quotient bit against a pre-shifted divisor.
    function automatic t_div_lane div_step(input t_div_lane lane,
                                           input logic [DIV_W-1:0] den_sh);
        t_div_lane nxt;
        nxt.quo = {lane.quo[QUO_W-2:0], 1'b0};
        nxt.rem = lane.rem;
        if (lane.rem >= den_sh) begin
            nxt.rem    = lane.rem - den_sh;
            nxt.quo[0] = 1'b1;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rth_prep.sv -----
// Front end: max, min, sector choice and the two division numerators.
`timescale 1ns / 1ps
`default_nettype none

module rth_prep (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire rth_pkg::t_rgb_pix  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rth_pkg::t_div_work      o_data
);
    import rth_pkg::*;

    logic [CH_W-1:0]  w_mx;
    logic [CH_W-1:0]  w_mn;
    logic [CH_W-1:0]  w_hi;
    logic [CH_W-1:0]  w_lo;
    t_sector          w_sector;

    logic [CH_W-1:0]  n_s1_mx;
    logic [CH_W-1:0]  n_s1_d;
    logic [SUM_W-1:0] n_s1_sum;
    logic [CH_W-1:0]  r_s1_mx;
    logic [CH_W-1:0]  r_s1_d;
    logic [SUM_W-1:0] r_s1_sum;
    t_sector          r_s1_sector;
    logic             r_s1_v;

    t_div_work        n_s2_work;
    t_div_work        r_s2_work;
    logic             r_s2_v;

    logic             w_load1;
    logic             w_load2;

    // Advance a stage when it is empty or its successor moves on.
    assign w_load2 = !r_s2_v || i_ready;
    assign w_load1 = !r_s1_v || w_load2;
    assign o_ready = w_load1;

    // Find max and min, pick the sector (red first, then green, then blue).
    always_comb begin
        w_mx = i_data.red;
        if (i_data.green > w_mx) w_mx = i_data.green;
        if (i_data.blue > w_mx) w_mx = i_data.blue;
        w_mn = i_data.red;
        if (i_data.green < w_mn) w_mn = i_data.green;
        if (i_data.blue < w_mn) w_mn = i_data.blue;

        if (i_data.red == w_mx) begin
            w_sector = SEC_RED;
            w_hi     = i_data.green;
            w_lo     = i_data.blue;
        end else if (i_data.green == w_mx) begin
            w_sector = SEC_GREEN;
            w_hi     = i_data.blue;
            w_lo     = i_data.red;
        end else begin
            w_sector = SEC_BLUE;
            w_hi     = i_data.red;
            w_lo     = i_data.green;
        end

        n_s1_mx  = w_mx;
        n_s1_d   = w_mx - w_mn;
        // Shift the channel difference by d so it never goes negative.
        n_s1_sum = {1'b0, w_hi} + {1'b0, n_s1_d} - {1'b0, w_lo};
    end

    // Stage 1 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_load1) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load1) begin
            r_s1_mx     <= n_s1_mx;
            r_s1_d      <= n_s1_d;
            r_s1_sum    <= n_s1_sum;
            r_s1_sector <= w_sector;
        end
    end

    // Build numerators and divisors for the round-to-nearest quotients.
    always_comb begin
        n_s2_work.hue.rem    = DIV_W'(HUE_SCALE2) * DIV_W'(r_s1_sum) + DIV_W'(r_s1_d);
        n_s2_work.hue.quo    = '0;
        n_s2_work.sat.rem    = DIV_W'(SAT_SCALE2) * DIV_W'(r_s1_d) + DIV_W'(r_s1_mx);
        n_s2_work.sat.quo    = '0;
        n_s2_work.hue_den    = {r_s1_d, 1'b0};
        n_s2_work.sat_den    = {r_s1_mx, 1'b0};
        n_s2_work.sector     = r_s1_sector;
        n_s2_work.grey       = (r_s1_d == '0);
        n_s2_work.brightness = r_s1_mx;
    end

    // Stage 2 registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_load2) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load2) begin
            r_s2_work <= n_s2_work;
        end
    end

    assign o_valid = r_s2_v;
    assign o_data  = r_s2_work;

endmodule

`default_nettype wire

// ----- rtl/core/rth_div.sv -----
// Pipelined restoring divider: one quotient bit per stage for hue and saturation.
`timescale 1ns / 1ps
`default_nettype none

module rth_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire rth_pkg::t_div_work  i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output rth_pkg::t_div_work       o_data
);
    import rth_pkg::*;

    logic      r_v    [QUO_W];
    t_div_work r_work [QUO_W];
    t_div_work n_work [QUO_W];
    logic      w_src_v [QUO_W];
    t_div_work w_src   [QUO_W];
    logic      w_dn_rdy[QUO_W];
    logic      w_load  [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++) begin : g_stage
            localparam int unsigned SH = QUO_W - 1 - k;

            // Hook up the stage's neighbors.
            if (k == 0) begin : g_first
                assign w_src_v[k] = i_valid;
                assign w_src[k]   = i_data;
            end else begin : g_mid
                assign w_src_v[k] = r_v[k-1];
                assign w_src[k]   = r_work[k-1];
            end
            if (k == QUO_W - 1) begin : g_last
                assign w_dn_rdy[k] = i_ready;
            end else begin : g_inner
                assign w_dn_rdy[k] = w_load[k+1];
            end

            assign w_load[k] = !r_v[k] || w_dn_rdy[k];

            // Resolve quotient bit SH of both lanes.
            always_comb begin
                n_work[k]     = w_src[k];
                n_work[k].hue = div_step(w_src[k].hue, DIV_W'(w_src[k].hue_den) << SH);
                n_work[k].sat = div_step(w_src[k].sat, DIV_W'(w_src[k].sat_den) << SH);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (w_load[k]) begin
                    r_v[k] <= w_src_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_load[k]) begin
                    r_work[k] <= n_work[k];
                end
            end
        end
    endgenerate

    assign o_ready = w_load[0];
    assign o_valid = r_v[QUO_W-1];
    assign o_data  = r_work[QUO_W-1];

endmodule

`default_nettype wire

// ----- rtl/core/rgb_to_hsv.sv -----
// Top level of the RGB to HSV pixel converter.
//
//   Channel   Valid     Ready     Payload   Carries
//   input     i_valid   o_ready   i_data    red, green, blue (8 bits each)
//   output    o_valid   i_ready   o_data    hue (15 bits), saturation, brightness
//
// One pixel per clock while the output is not stalled; 2 front-end stages, 13 divider
// stages (one quotient bit each, set by the 13-bit hue quotient), 1 output stage.
// Reset clears every stage's valid bit; payload registers are not reset.
// Each stage loads when it is empty or its successor moves, so a stalled
// output lets upstream bubbles close up and nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_hsv_defines.svh"

module rgb_to_hsv (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire rth_pkg::t_rgb_pix  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output rth_pkg::t_hsv_pix       o_data
);
    import rth_pkg::*;

    logic             w_prep_v;
    logic             w_prep_rdy;
    t_div_work        w_prep_work;
    logic             w_div_v;
    logic             w_div_rdy;
    t_div_work        w_div_work;

    logic [HUE_W-1:0] w_ofs;
    logic [HUE_W-1:0] w_hue;
    t_hsv_pix         n_out;
    t_hsv_pix         r_out;
    logic             r_out_v;
    logic             w_load_out;

    rth_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (w_prep_v),
        .i_ready (w_prep_rdy),
        .o_data  (w_prep_work)
    );

    rth_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_prep_v),
        .o_ready (w_prep_rdy),
        .i_data  (w_prep_work),
        .o_valid (w_div_v),
        .i_ready (w_div_rdy),
        .o_data  (w_div_work)
    );

    assign w_load_out = !r_out_v || i_ready;
    assign w_div_rdy  = w_load_out;

    // Add the sector offset, wrap past 360 degrees, zero hue and saturation on grey.
    always_comb begin
        case (w_div_work.sector)
            SEC_RED:   w_ofs = OFS_RED;
            SEC_GREEN: w_ofs = OFS_GREEN;
            SEC_BLUE:  w_ofs = OFS_BLUE;
            default:   w_ofs = OFS_RED;
        endcase
        w_hue = w_ofs + HUE_W'(w_div_work.hue.quo);
        if (w_hue >= HUE_FULL) begin
            w_hue = w_hue - HUE_FULL;
        end

        n_out.brightness = w_div_work.brightness;
        if (w_div_work.grey) begin
            n_out.hue        = '0;
            n_out.saturation = '0;
        end else begin
            n_out.hue        = w_hue;
            n_out.saturation = w_div_work.sat.quo[CH_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_load_out) begin
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    `RTH_ASSERT(a_hue_range, o_valid |-> (o_data.hue < HUE_FULL), "hue out of range")
    `RTH_ASSERT(a_grey_hue, (o_valid && (o_data.saturation == '0)) |-> (o_data.hue == '0), "grey pixel with nonzero hue")
    `RTH_ASSERT(a_black_sat, (o_valid && (o_data.brightness == '0)) |-> (o_data.saturation == '0), "black pixel with nonzero saturation")
    `RTH_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

`default_nettype wire

// ----- dv/hsv_predict_check.sv -----
// Predicts HSV pixels from accepted RGB transfers and compares them with the output channel.
`timescale 1ns / 1ps

module hsv_predict_check (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_pix_valid,
    input  wire logic              i_pix_ready,
    input  wire rth_pkg::t_rgb_pix i_pix,
    input  wire logic              i_hsv_valid,
    input  wire logic              i_hsv_ready,
    input  wire rth_pkg::t_hsv_pix i_hsv,
    output int                     o_fail_count,
    output int                     o_pending
);
    import rth_pkg::*;

    // Hue is carried in degrees times 64.
    localparam longint DEG_60  = 3840;
    localparam longint DEG_120 = 7680;
    localparam longint DEG_240 = 15360;
    localparam longint DEG_360 = 23040;

    typedef struct {
        t_rgb_pix src;
        t_hsv_pix want;
    } t_hsv_due;

    t_hsv_due hsv_due[$];

    // Convert one pixel with exact integer arithmetic, ties rounding upward.
    function automatic t_hsv_pix hsv_of(t_rgb_pix px);
        longint  r, g, b, mx, mn, d, hi, lo, base, num, hue_l, sat_l;
        t_sector sec;
        t_hsv_pix res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        hue_l = 0;
        sat_l = 0;
        if (d != 0) begin
            // Red wins ties, then green.
            if (mx == r) sec = SEC_RED;
            else if (mx == g) sec = SEC_GREEN;
            else sec = SEC_BLUE;
            case (sec)
                SEC_RED: begin
                    hi = g;
                    lo = b;
                    base = (g >= b) ? 0 : DEG_360;
                end
                SEC_GREEN: begin
                    hi = b;
                    lo = r;
                    base = DEG_120;
                end
                default: begin
                    hi = r;
                    lo = g;
                    base = DEG_240;
                end
            endcase
            num = DEG_60 * (hi - lo) + base * d;
            if (num < 0) num = 0;
            hue_l = (2 * num + d) / (2 * d);
            if (hue_l >= DEG_360) hue_l -= DEG_360;
        end
        if (mx != 0) sat_l = (510 * d + mx) / (2 * mx);
        if (sat_l > 255) sat_l = 255;
        res.hue        = hue_l[HUE_W-1:0];
        res.saturation = sat_l[CH_W-1:0];
        res.brightness = mx[CH_W-1:0];
        return res;
    endfunction

    // Print one mismatch line and count it.
    task automatic report(string what);
        $display("%0t ns: mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Compare each output transfer with the oldest prediction, then queue new ones.
    always @(posedge i_clk) begin
        t_hsv_due head;
        if (i_rst_n) begin
            if (i_hsv_valid && i_hsv_ready) begin
                if (hsv_due.size() == 0) begin
                    report($sformatf("unexpected output hue=%0d sat=%0d val=%0d",
                                     i_hsv.hue, i_hsv.saturation, i_hsv.brightness));
                end else begin
                    head = hsv_due.pop_front();
                    if (i_hsv.hue !== head.want.hue)
                        report($sformatf("rgb=(%0d,%0d,%0d) hue got %0d want %0d",
                                         head.src.red, head.src.green, head.src.blue,
                                         i_hsv.hue, head.want.hue));
                    if (i_hsv.saturation !== head.want.saturation)
                        report($sformatf("rgb=(%0d,%0d,%0d) sat got %0d want %0d",
                                         head.src.red, head.src.green, head.src.blue,
                                         i_hsv.saturation, head.want.saturation));
                    if (i_hsv.brightness !== head.want.brightness)
                        report($sformatf("rgb=(%0d,%0d,%0d) val got %0d want %0d",
                                         head.src.red, head.src.green, head.src.blue,
                                         i_hsv.brightness, head.want.brightness));
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                head.src  = i_pix;
                head.want = hsv_of(i_pix);
                hsv_due.push_back(head);
            end
        end
        o_pending = hsv_due.size();
    end

endmodule

// ----- dv/tb_top.sv -----
// Stimulus, clock, reset and verdict for the RGB to HSV converter.
`timescale 1ns / 1ps

module tb_top;
    import rth_pkg::*;

    localparam int RANDOM_PIXELS = 1300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 40;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     pix_valid = 1'b0;
    t_rgb_pix pix_data = '0;
    logic     pix_ready;
    logic     hsv_valid;
    logic     hsv_ready = 1'b0;
    t_hsv_pix hsv_data;
    int       fail_count;
    int       pending;
    int       cycles = 0;
    bit       calm = 1'b0;

    rgb_to_hsv i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pix_valid),
        .o_ready (pix_ready),
        .i_data  (pix_data),
        .o_valid (hsv_valid),
        .i_ready (hsv_ready),
        .o_data  (hsv_data)
    );

    hsv_predict_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (pix_valid),
        .i_pix_ready  (pix_ready),
        .i_pix        (pix_data),
        .i_hsv_valid  (hsv_valid),
        .i_hsv_ready  (hsv_ready),
        .i_hsv        (hsv_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stall the output side at random, except during the calm stretch.
    initial begin
        forever begin
            @(negedge i_clk);
            hsv_ready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
        end
    end

    // Offer one pixel, with random idle cycles ahead of it, and hold until the transfer.
    task automatic send_pixel(t_rgb_pix px);
        while (!calm && $urandom_range(99) < 19) begin
            pix_valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        @(posedge i_clk);
        while (!pix_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_rgb_pix px;
        int       base, m, pick;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners: black, white, greys and primaries.
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd128, 8'd128});
        send_pixel({8'd1, 8'd1, 8'd1});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd255});
        // Red sector with blue above green: hue comes back around from 360.
        send_pixel({8'd255, 8'd0, 8'd1});
        send_pixel({8'd255, 8'd0, 8'd254});
        // Sector ties: red beats green and blue, green beats blue.
        send_pixel({8'd255, 8'd255, 8'd0});
        send_pixel({8'd255, 8'd0, 8'd255});
        send_pixel({8'd0, 8'd255, 8'd255});
        send_pixel({8'd7, 8'd7, 8'd7});
        // Smallest spreads and smallest maxima.
        send_pixel({8'd1, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd1, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd1});
        send_pixel({8'd255, 8'd254, 8'd254});
        send_pixel({8'd3, 8'd2, 8'd1});
        // Assorted mid-range hues, with rounding near half steps.
        send_pixel({8'd128, 8'd64, 8'd32});
        send_pixel({8'd32, 8'd64, 8'd128});
        send_pixel({8'd200, 8'd100, 8'd150});
        send_pixel({8'd17, 8'd200, 8'd3});
        send_pixel({8'd100, 8'd1, 8'd255});
        send_pixel({8'd254, 8'd127, 8'd0});
        send_pixel({8'd85, 8'd170, 8'd255});

        // Random pixels, mostly uniform, with near-greys, ties, tiny values and full-scale red and blue mixed in.
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            calm = (n >= 500 && n < 800);
            pick = $urandom_range(9);
            px.red   = 8'($urandom_range(255));
            px.green = 8'($urandom_range(255));
            px.blue  = 8'($urandom_range(255));
            case (pick)
                6: begin
                    base = $urandom_range(255);
                    px.red   = 8'(base);
                    m = base + $urandom_range(4) - 2;
                    px.green = (m < 0) ? 8'd0 : (m > 255) ? 8'd255 : 8'(m);
                    m = base + $urandom_range(4) - 2;
                    px.blue  = (m < 0) ? 8'd0 : (m > 255) ? 8'd255 : 8'(m);
                end
                7: begin
                    m = $urandom_range(1, 255);
                    case ($urandom_range(2))
                        0: begin
                            px.red   = 8'(m);
                            px.green = 8'(m);
                            px.blue  = 8'($urandom_range(m));
                        end
                        1: begin
                            px.red   = 8'(m);
                            px.blue  = 8'(m);
                            px.green = 8'($urandom_range(m));
                        end
                        default: begin
                            px.green = 8'(m);
                            px.blue  = 8'(m);
                            px.red   = 8'($urandom_range(m));
                        end
                    endcase
                end
                8: begin
                    px.red   = 8'($urandom_range(3));
                    px.green = 8'($urandom_range(3));
                    px.blue  = 8'($urandom_range(3));
                end
                9: begin
                    px.red   = $urandom_range(1) ? 8'd255 : 8'd0;
                    px.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
                end
                default: ;
            endcase
            send_pixel(px);
        end
        calm = 1'b0;
        pix_valid <= 1'b0;

        // Drain the pipeline, then watch for stray outputs.
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
